@@ rtl/hmsct_pkg.sv @@
// shared types and constants for the countdown alarm timer
`timescale 1ns / 1ps
`default_nettype none

package hmsct_pkg;

   localparam int unsigned CountWidth = 8;

   typedef logic [CountWidth-1:0] count_type;

   typedef enum logic {
      KIND_TICK = 1'b0,
      KIND_LOAD = 1'b1
   } kind_type;

   localparam count_type SEC_RELOAD    = count_type'(59);
   localparam count_type PERIOD_RESET  = count_type'(5);

   // one captured input transfer
   typedef struct packed {
      kind_type  kind;
      count_type load_minutes;
      count_type load_seconds;
      logic      running;
   } request_type;

   // one result transfer
   typedef struct packed {
      count_type hours_left;
      count_type minutes_left;
      count_type seconds_left;
      logic      done_res;
      logic      active;
      logic      buzzer_on;
      count_type beeps;
      logic      sample_request;
      logic      control_request;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/hms_countdown_alarm_timer.sv @@
// countdown timer with end-of-count alarm and sample request pacing
// path: an accepted transfer passes the input register, then the result register, to the result port
// throughput: one item per cycle while the receiver does not stall; an input register and a result register
//   each take a new item whenever the stage after them moves on
// reset: synchronous, active high; counters, flags, divider and both valids clear,
//   sample period returns to 5
`timescale 1ns / 1ps
`default_nettype none

module hms_countdown_alarm_timer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write,
   input  wire hmsct_pkg::count_type csr_wdata,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire hmsct_pkg::kind_type req_kind,
   input  wire hmsct_pkg::count_type req_load_minutes,
   input  wire hmsct_pkg::count_type req_load_seconds,
   input  wire logic                req_running,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output hmsct_pkg::count_type     rsp_hours_left,
   output hmsct_pkg::count_type     rsp_minutes_left,
   output hmsct_pkg::count_type     rsp_seconds_left,
   output logic                     rsp_done_res,
   output logic                     rsp_active,
   output logic                     rsp_buzzer_on,
   output hmsct_pkg::count_type     rsp_beeps,
   output logic                     rsp_sample_request,
   output logic                     rsp_control_request
);
   import hmsct_pkg::*;

   count_type   period_ff;
   logic        req_valid_ff;
   request_type req_ff;
   logic        rsp_valid_ff;
   result_type  rsp_ff;

   count_type   hours_ff, hours_in;
   count_type   minutes_ff, minutes_in;
   count_type   seconds_ff, seconds_in;
   logic        done_ff, done_in;
   logic        active_ff, active_in;
   logic        buzzer_ff, buzzer_in;
   count_type   beeps_ff, beeps_in;
   count_type   divider_ff, divider_in;
   count_type   divider_inc;
   logic        sample_req, control_req;
   logic        at_zero;

   logic        rsp_load;
   logic        stage_move;
   logic        req_take;

   assign rsp_load   = !rsp_valid_ff || !rsp_stall;
   assign stage_move = req_valid_ff && rsp_load;
   assign req_stall  = req_valid_ff && !rsp_load;
   assign req_take   = req_valid && !req_stall;

   assign at_zero     = (hours_ff == '0) && (minutes_ff == '0) && (seconds_ff == '0);
   assign divider_inc = divider_ff + count_type'(1);

   always_comb begin
      hours_in    = hours_ff;
      minutes_in  = minutes_ff;
      seconds_in  = seconds_ff;
      done_in     = done_ff;
      active_in   = active_ff;
      buzzer_in   = buzzer_ff;
      beeps_in    = beeps_ff;
      divider_in  = divider_ff;
      sample_req  = 1'b0;
      control_req = 1'b0;
      if (req_ff.kind == KIND_LOAD) begin
         hours_in   = '0;
         minutes_in = req_ff.load_minutes;
         seconds_in = req_ff.load_seconds;
         done_in    = 1'b0;
         active_in  = 1'b1;
         beeps_in   = '0;
      end else if (done_ff) begin
         beeps_in  = beeps_ff + count_type'(1);
         buzzer_in = !buzzer_ff;
      end else if (active_ff && at_zero) begin
         done_in   = 1'b1;
         active_in = 1'b0;
      end else begin
         // borrow chain, holds at 00:00:00
         if (seconds_ff != '0) begin
            seconds_in = seconds_ff - count_type'(1);
         end else if (minutes_ff != '0) begin
            seconds_in = SEC_RELOAD;
            minutes_in = minutes_ff - count_type'(1);
         end else if (hours_ff != '0) begin
            seconds_in = SEC_RELOAD;
            minutes_in = SEC_RELOAD;
            hours_in   = hours_ff - count_type'(1);
         end
         divider_in = divider_inc;
         if (req_ff.running && (divider_inc >= period_ff)) begin
            divider_in = '0;
            sample_req = 1'b1;
         end
         control_req = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= PERIOD_RESET;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hours_ff     <= '0;
         minutes_ff   <= '0;
         seconds_ff   <= '0;
         done_ff      <= 1'b0;
         active_ff    <= 1'b0;
         buzzer_ff    <= 1'b0;
         beeps_ff     <= '0;
         divider_ff   <= '0;
      end else begin
         if (csr_write) begin
            period_ff <= csr_wdata;
         end
         if (req_take) begin
            req_valid_ff <= 1'b1;
         end else if (stage_move) begin
            req_valid_ff <= 1'b0;
         end
         if (rsp_load) begin
            rsp_valid_ff <= req_valid_ff;
         end
         if (stage_move) begin
            hours_ff   <= hours_in;
            minutes_ff <= minutes_in;
            seconds_ff <= seconds_in;
            done_ff    <= done_in;
            active_ff  <= active_in;
            buzzer_ff  <= buzzer_in;
            beeps_ff   <= beeps_in;
            divider_ff <= divider_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.kind         <= req_kind;
         req_ff.load_minutes <= req_load_minutes;
         req_ff.load_seconds <= req_load_seconds;
         req_ff.running      <= req_running;
      end
      if (stage_move) begin
         rsp_ff.hours_left      <= hours_in;
         rsp_ff.minutes_left    <= minutes_in;
         rsp_ff.seconds_left    <= seconds_in;
         rsp_ff.done_res        <= done_in;
         rsp_ff.active          <= active_in;
         rsp_ff.buzzer_on       <= buzzer_in;
         rsp_ff.beeps           <= beeps_in;
         rsp_ff.sample_request  <= sample_req;
         rsp_ff.control_request <= control_req;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hours_left      = rsp_ff.hours_left;
   assign rsp_minutes_left    = rsp_ff.minutes_left;
   assign rsp_seconds_left    = rsp_ff.seconds_left;
   assign rsp_done_res        = rsp_ff.done_res;
   assign rsp_active          = rsp_ff.active;
   assign rsp_buzzer_on       = rsp_ff.buzzer_on;
   assign rsp_beeps           = rsp_ff.beeps;
   assign rsp_sample_request  = rsp_ff.sample_request;
   assign rsp_control_request = rsp_ff.control_request;

endmodule

`default_nettype wire

@@ rtl/hmsct_checker.sv @@
// port-level checks for the countdown alarm timer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module hmsct_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire hmsct_pkg::count_type rsp_hours_left,
   input wire hmsct_pkg::count_type rsp_minutes_left,
   input wire hmsct_pkg::count_type rsp_seconds_left,
   input wire logic                 rsp_done_res,
   input wire logic                 rsp_active,
   input wire hmsct_pkg::count_type rsp_beeps,
   input wire logic                 rsp_sample_request,
   input wire logic                 rsp_control_request
);
   import hmsct_pkg::*;

   // nothing left over from before reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result transfer holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hours_left)
         && $stable(rsp_minutes_left) && $stable(rsp_seconds_left)
         && $stable(rsp_beeps))
      else $error("stalled result changed");

   // a sample request only comes with a counting tick
   a_sample_with_control: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_request |-> rsp_control_request)
      else $error("sample request without control request");

   a_done_not_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_done_res && rsp_active))
      else $error("done and active together");

   // counting ticks never happen once done
   a_control_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_control_request |-> !rsp_done_res)
      else $error("control request while done");

endmodule

bind hms_countdown_alarm_timer hmsct_checker u_hmsct_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_hours_left      (rsp_hours_left),
   .rsp_minutes_left    (rsp_minutes_left),
   .rsp_seconds_left    (rsp_seconds_left),
   .rsp_done_res        (rsp_done_res),
   .rsp_active          (rsp_active),
   .rsp_beeps           (rsp_beeps),
   .rsp_sample_request  (rsp_sample_request),
   .rsp_control_request (rsp_control_request)
);

`default_nettype wire

@@ test/hmsct_result_checker.sv @@
// result checker for the countdown alarm timer: predicts each result and compares it
`timescale 1ns / 1ps

module hmsct_result_checker (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write,
   input  wire hmsct_pkg::count_type csr_wdata,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire hmsct_pkg::kind_type  req_kind,
   input  wire hmsct_pkg::count_type req_load_minutes,
   input  wire hmsct_pkg::count_type req_load_seconds,
   input  wire logic                 req_running,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire hmsct_pkg::count_type rsp_hours_left,
   input  wire hmsct_pkg::count_type rsp_minutes_left,
   input  wire hmsct_pkg::count_type rsp_seconds_left,
   input  wire logic                 rsp_done_res,
   input  wire logic                 rsp_active,
   input  wire logic                 rsp_buzzer_on,
   input  wire hmsct_pkg::count_type rsp_beeps,
   input  wire logic                 rsp_sample_request,
   input  wire logic                 rsp_control_request,
   output int                        mismatch_count,
   output int                        outstanding,
   output int                        results_checked
);
   import hmsct_pkg::*;

   // own copy of the timer state and the sample period
   count_type tmr_hours;
   count_type tmr_minutes;
   count_type tmr_seconds;
   logic      tmr_done;
   logic      tmr_active;
   logic      tmr_buzzer;
   count_type tmr_beeps;
   count_type tmr_divider;
   count_type tmr_period;

   result_type readout_queue[$];

   function automatic result_type step_countdown(request_type rq);
      result_type r;
      logic       sample_hit;
      logic       control_hit;
      sample_hit  = 1'b0;
      control_hit = 1'b0;
      if (rq.kind == KIND_LOAD) begin
         tmr_hours   = '0;
         tmr_minutes = rq.load_minutes;
         tmr_seconds = rq.load_seconds;
         tmr_done    = 1'b0;
         tmr_active  = 1'b1;
         tmr_beeps   = '0;
      end else if (tmr_done) begin
         // alarm ticks only toggle the buzzer and count beeps
         tmr_beeps  = tmr_beeps + count_type'(1);
         tmr_buzzer = ~tmr_buzzer;
      end else if (tmr_active && tmr_hours == '0 && tmr_minutes == '0 && tmr_seconds == '0)
      begin
         tmr_done   = 1'b1;
         tmr_active = 1'b0;
      end else begin
         if (tmr_seconds != '0) begin
            tmr_seconds = tmr_seconds - count_type'(1);
         end else if (tmr_minutes != '0) begin
            tmr_seconds = SEC_RELOAD;
            tmr_minutes = tmr_minutes - count_type'(1);
         end else if (tmr_hours != '0) begin
            tmr_seconds = SEC_RELOAD;
            tmr_minutes = SEC_RELOAD;
            tmr_hours   = tmr_hours - count_type'(1);
         end
         tmr_divider = tmr_divider + count_type'(1);
         if (rq.running && tmr_divider >= tmr_period) begin
            tmr_divider = '0;
            sample_hit  = 1'b1;
         end
         control_hit = 1'b1;
      end
      r.hours_left      = tmr_hours;
      r.minutes_left    = tmr_minutes;
      r.seconds_left    = tmr_seconds;
      r.done_res        = tmr_done;
      r.active          = tmr_active;
      r.buzzer_on       = tmr_buzzer;
      r.beeps           = tmr_beeps;
      r.sample_request  = sample_hit;
      r.control_request = control_hit;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch at %0t on result %0d: %s expected %0d, got %0d",
                     $realtime, results_checked, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      request_type rq;
      result_type  want;
      result_type  got;
      if (reset) begin
         tmr_hours       = '0;
         tmr_minutes     = '0;
         tmr_seconds     = '0;
         tmr_done        = 1'b0;
         tmr_active      = 1'b0;
         tmr_buzzer      = 1'b0;
         tmr_beeps       = '0;
         tmr_divider     = '0;
         tmr_period      = PERIOD_RESET;
         readout_queue.delete();
         mismatch_count  = 0;
         results_checked = 0;
         outstanding    <= 0;
      end else begin
         if (csr_write)
            tmr_period = csr_wdata;
         if (req_valid && !req_stall) begin
            rq.kind         = req_kind;
            rq.load_minutes = req_load_minutes;
            rq.load_seconds = req_load_seconds;
            rq.running      = req_running;
            readout_queue.push_back(step_countdown(rq));
         end
         if (rsp_valid && !rsp_stall) begin
            got.hours_left      = rsp_hours_left;
            got.minutes_left    = rsp_minutes_left;
            got.seconds_left    = rsp_seconds_left;
            got.done_res        = rsp_done_res;
            got.active          = rsp_active;
            got.buzzer_on       = rsp_buzzer_on;
            got.beeps           = rsp_beeps;
            got.sample_request  = rsp_sample_request;
            got.control_request = rsp_control_request;
            if (readout_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch at %0t: result transfer with nothing pending", $realtime);
            end else begin
               want = readout_queue.pop_front();
               check_field("hours_left", want.hours_left, got.hours_left);
               check_field("minutes_left", want.minutes_left, got.minutes_left);
               check_field("seconds_left", want.seconds_left, got.seconds_left);
               check_field("done_res", 8'(want.done_res), 8'(got.done_res));
               check_field("active", 8'(want.active), 8'(got.active));
               check_field("buzzer_on", 8'(want.buzzer_on), 8'(got.buzzer_on));
               check_field("beeps", want.beeps, got.beeps);
               check_field("sample_request", 8'(want.sample_request),
                           8'(got.sample_request));
               check_field("control_request", 8'(want.control_request),
                           8'(got.control_request));
            end
            results_checked++;
         end
         outstanding <= readout_queue.size();
      end
   end

endmodule

@@ test/tb_hms_countdown_alarm_timer.sv @@
// testbench top for the countdown alarm timer: stimulus phases, idling and verdict
`timescale 1ns / 1ps

module tb_hms_countdown_alarm_timer;
   import hmsct_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int HoldCycles = 300;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      csr_write = 1'b0;
   count_type csr_wdata = '0;
   logic      req_valid = 1'b0;
   logic      req_stall;
   kind_type  req_kind = KIND_TICK;
   count_type req_load_minutes = '0;
   count_type req_load_seconds = '0;
   logic      req_running = 1'b0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   count_type rsp_hours_left;
   count_type rsp_minutes_left;
   count_type rsp_seconds_left;
   logic      rsp_done_res;
   logic      rsp_active;
   logic      rsp_buzzer_on;
   count_type rsp_beeps;
   logic      rsp_sample_request;
   logic      rsp_control_request;

   int mismatch_count;
   int outstanding;
   int results_checked;

   int   sender_idle_pct = 0;
   int   recv_stall_pct = 0;
   logic hold_armed = 1'b0;
   logic hold_done = 1'b0;
   int   hold_count = 0;
   int   cycle_count = 0;
   int   items_sent = 0;

   hms_countdown_alarm_timer uut (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_load_minutes    (req_load_minutes),
      .req_load_seconds    (req_load_seconds),
      .req_running         (req_running),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_hours_left      (rsp_hours_left),
      .rsp_minutes_left    (rsp_minutes_left),
      .rsp_seconds_left    (rsp_seconds_left),
      .rsp_done_res        (rsp_done_res),
      .rsp_active          (rsp_active),
      .rsp_buzzer_on       (rsp_buzzer_on),
      .rsp_beeps           (rsp_beeps),
      .rsp_sample_request  (rsp_sample_request),
      .rsp_control_request (rsp_control_request)
   );

   hmsct_result_checker readout_check (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_load_minutes    (req_load_minutes),
      .req_load_seconds    (req_load_seconds),
      .req_running         (req_running),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_hours_left      (rsp_hours_left),
      .rsp_minutes_left    (rsp_minutes_left),
      .rsp_seconds_left    (rsp_seconds_left),
      .rsp_done_res        (rsp_done_res),
      .rsp_active          (rsp_active),
      .rsp_buzzer_on       (rsp_buzzer_on),
      .rsp_beeps           (rsp_beeps),
      .rsp_sample_request  (rsp_sample_request),
      .rsp_control_request (rsp_control_request),
      .mismatch_count      (mismatch_count),
      .outstanding         (outstanding),
      .results_checked     (results_checked)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count, outstanding);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_armed && !hold_done) begin
         rsp_stall  <= 1'b1;
         hold_count <= hold_count + 1;
         if (hold_count == HoldCycles - 1)
            hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   function automatic request_type make_item(kind_type k, count_type m, count_type s, logic run);
      request_type rq;
      rq.kind         = k;
      rq.load_minutes = m;
      rq.load_seconds = s;
      rq.running      = run;
      return rq;
   endfunction

   // mostly ticks, with short loads so that counts reach the alarm
   function automatic request_type random_item();
      request_type rq;
      rq.kind         = ($urandom_range(99) < 8) ? KIND_LOAD : KIND_TICK;
      rq.load_minutes = ($urandom_range(5) == 0) ? count_type'($urandom) : '0;
      rq.load_seconds = ($urandom_range(5) == 0) ? count_type'($urandom)
                                                 : count_type'($urandom_range(10));
      rq.running      = 1'($urandom_range(1));
      return rq;
   endfunction

   task automatic send_item(input request_type rq);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= rq.kind;
      req_load_minutes <= rq.load_minutes;
      req_load_seconds <= rq.load_seconds;
      req_running      <= rq.running;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_period(input count_type value);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part, period still at its reset value
      send_item(make_item(KIND_TICK, 8'hff, 8'hff, 1'b1));  // idle tick at zero still counts
      send_item(make_item(KIND_TICK, 8'h00, 8'h00, 1'b0));
      send_item(make_item(KIND_LOAD, 8'h00, 8'h00, 1'b1));  // zero load: next tick sets done
      send_item(make_item(KIND_TICK, 8'h00, 8'h00, 1'b1));
      repeat (2) send_item(make_item(KIND_TICK, 8'hff, 8'h00, 1'b1));
      send_item(make_item(KIND_LOAD, 8'h00, 8'h02, 1'b1));  // restart while done
      repeat (3) send_item(make_item(KIND_TICK, 8'h00, 8'hff, 1'b1));
      send_item(make_item(KIND_LOAD, 8'hff, 8'hff, 1'b0));
      repeat (3) send_item(make_item(KIND_TICK, 8'h00, 8'h00, 1'b1));
      send_item(make_item(KIND_LOAD, 8'h01, 8'h00, 1'b1));  // restart while active
      repeat (3) send_item(make_item(KIND_TICK, 8'h5a, 8'ha5, 1'b1));
      send_item(make_item(KIND_LOAD, 8'h00, 8'h3c, 1'b1));  // seconds above the reload value
      send_item(make_item(KIND_TICK, 8'h00, 8'h00, 1'b1));
      send_item(make_item(KIND_LOAD, 8'h00, 8'h01, 1'b0));
      repeat (3) send_item(make_item(KIND_TICK, 8'h00, 8'h00, 1'b0));
      wait_for_drain();

      write_period(8'd1);
      sender_idle_pct = 62;
      recv_stall_pct  = 0;
      repeat (200) send_item(random_item());
      wait_for_drain();

      // long non-running count so the divider wraps
      write_period(8'd255);
      sender_idle_pct = 0;
      recv_stall_pct  = 62;
      send_item(make_item(KIND_LOAD, 8'hff, 8'hff, 1'b0));
      repeat (270) send_item(make_item(KIND_TICK, count_type'($urandom), count_type'($urandom),
                                       1'b0));
      repeat (8) send_item(make_item(KIND_TICK, 8'h00, 8'h00, 1'b1));
      wait_for_drain();

      write_period(8'd0);
      sender_idle_pct = 28;
      recv_stall_pct  = 28;
      repeat (180) send_item(random_item());
      wait_for_drain();

      // receiver holds off while the sender keeps offering transfers
      write_period(8'd3);
      sender_idle_pct = 0;
      recv_stall_pct  = 0;
      hold_armed     <= 1'b1;
      repeat (40) send_item(random_item());
      hold_armed     <= 1'b0;
      wait_for_drain();

      // long alarm so the beep count wraps
      write_period(count_type'($urandom_range(254, 2)));
      sender_idle_pct = 28;
      recv_stall_pct  = 28;
      send_item(make_item(KIND_LOAD, 8'h00, 8'h02, 1'b1));
      repeat (265) send_item(make_item(KIND_TICK, count_type'($urandom), count_type'($urandom),
                                       1'($urandom_range(1))));
      wait_for_drain();

      write_period(PERIOD_RESET);
      sender_idle_pct = 0;
      recv_stall_pct  = 0;
      repeat (170) send_item(random_item());
      wait_for_drain();
      repeat (8) @(posedge clock);

      $display("covered %0d transfers over seven phases: periods 5, 1, 255, 0, 3, random, 5",
               items_sent);
      $display("%0d results checked, incl. a long receiver hold, divider and beep wraps",
               results_checked);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
